// ===== rtl/core/mpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
package mpq_pkg;

    // Field widths of the input and result items
    localparam int REQ_W     = 2;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 9;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_EXTRACT  = 2'd1,
        REQ_INCREASE = 2'd2,
        REQ_PEEK     = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BADPOS    = 3'd3,
        ST_NOTLARGER = 3'd4
    } status_t;

    // Controller states, one-hot
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOAD   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_UP_RD  = 8'b0000_1000,
        S_UP_EV  = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_EV  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch a new request
        logic decide;    // check request, set up the sift
        logic rd_up;     // read parent of the hole
        logic ev_up;     // sift-up step, writes one entry
        logic rd_dn;     // read both children of the hole
        logic ev_dn;     // sift-down step, writes one entry
        logic load_out;  // move result into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic go_up;     // request needs a sift-up
        logic go_dn;     // request needs a sift-down
        logic up_more;   // sift-up continues one level higher
        logic dn_more;   // sift-down continues one level lower
    } stat_t;

endpackage

// ===== rtl/core/max_priority_queue_unit.sv =====
// Top level of the max-heap priority queue of signed 32-bit keys.
//
// Requests arrive on the s_ stream, one item each: insert, extract maximum,
// increase key at a heap position, or peek maximum. Every request gives
// exactly one result item on the m_ stream: the maximum key (extract and
// peek), a status code and the occupancy after the request.
// Keys sit in a CAPACITY-entry memory with two read ports and one write port.
// A request with no sift (peek, errors) goes from accept through the load,
// decide and done states back to idle. Insert, increase and extract add a
// read state and an evaluate state per heap level visited by the sift, at
// most log2(CAPACITY)+1 levels: the sift loop does one memory read then one
// compare and write per level.
// One request is worked on at a time; s_tready is high only while idle.
// A finished result waits in the output register while the next request is
// accepted; the block stalls before its result only if that register is full.
// Reset empties the heap and drops any pending result; memory contents are
// not cleared, since no entry is read before it is written.
module max_priority_queue_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request: req_type[1:0], key_value[33:2], position[41:34]
    input  logic [mpq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // result: result_key[31:0], status[34:32], occupancy[43:35]
    output logic [mpq_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    localparam int KEY_LSB = mpq_pkg::REQ_W;
    localparam int POS_LSB = KEY_LSB + mpq_pkg::KEY_W;
    localparam int M_USED  = mpq_pkg::KEY_W + mpq_pkg::STATUS_W + mpq_pkg::OCC_W;

    mpq_pkg::cmd_t                    cmd;
    mpq_pkg::stat_t                   stat;
    logic signed [mpq_pkg::KEY_W-1:0] m_key;
    logic [mpq_pkg::STATUS_W-1:0]     m_status;
    logic [mpq_pkg::OCC_W-1:0]        m_occ;

    mpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_req    (s_tdata[mpq_pkg::REQ_W-1:0]),
        .s_key    (s_tdata[POS_LSB-1:KEY_LSB]),
        .s_pos    (s_tdata[POS_LSB+mpq_pkg::POS_W-1:POS_LSB]),
        .m_key    (m_key),
        .m_status (m_status),
        .m_occ    (m_occ)
    );

    // Pack the result fields, zero fill to whole bytes
    assign m_tdata = {{(mpq_pkg::M_TDATA_W - M_USED){1'b0}}, m_occ, m_status, m_key};

endmodule

// ===== rtl/core/mpq_ctrl.sv =====
// Controller state machine for the max-heap priority queue.
module mpq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  mpq_pkg::stat_t stat,
    output mpq_pkg::cmd_t  cmd
);

    mpq_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign s_tready = (state_reg == mpq_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mpq_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = mpq_pkg::S_LOAD;
                end
            end
            mpq_pkg::S_LOAD: begin
                state_next = mpq_pkg::S_DECIDE;
            end
            mpq_pkg::S_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.go_up) begin
                    state_next = mpq_pkg::S_UP_RD;
                end else if (stat.go_dn) begin
                    state_next = mpq_pkg::S_DN_RD;
                end else begin
                    state_next = mpq_pkg::S_DONE;
                end
            end
            mpq_pkg::S_UP_RD: begin
                cmd.rd_up  = 1'b1;
                state_next = mpq_pkg::S_UP_EV;
            end
            mpq_pkg::S_UP_EV: begin
                cmd.ev_up  = 1'b1;
                state_next = stat.up_more ? mpq_pkg::S_UP_RD : mpq_pkg::S_DONE;
            end
            mpq_pkg::S_DN_RD: begin
                cmd.rd_dn  = 1'b1;
                state_next = mpq_pkg::S_DN_EV;
            end
            mpq_pkg::S_DN_EV: begin
                cmd.ev_dn  = 1'b1;
                state_next = stat.dn_more ? mpq_pkg::S_DN_RD : mpq_pkg::S_DONE;
            end
            mpq_pkg::S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = mpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mpq_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: held until taken, set when a result is loaded
    assign m_tvalid_next = (m_tvalid_reg && !m_tready) || cmd.load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mpq_pkg::S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== rtl/core/mpq_datapath.sv =====
// Datapath of the max-heap priority queue: key memory, hole index, result registers.
module mpq_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mpq_pkg::cmd_t                     cmd,
    output mpq_pkg::stat_t                    stat,
    input  logic [mpq_pkg::REQ_W-1:0]         s_req,
    input  logic signed [mpq_pkg::KEY_W-1:0]  s_key,
    input  logic [mpq_pkg::POS_W-1:0]         s_pos,
    output logic signed [mpq_pkg::KEY_W-1:0]  m_key,
    output logic [mpq_pkg::STATUS_W-1:0]      m_status,
    output logic [mpq_pkg::OCC_W-1:0]         m_occ
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = IW + 2;
    localparam int PCW = CW + mpq_pkg::POS_W;

    // Key memory, two registered read ports, one write port
    logic signed [mpq_pkg::KEY_W-1:0] key_mem [CAPACITY];
    logic [IW-1:0]                    addr_a, addr_b;
    logic                             mem_we;
    logic signed [mpq_pkg::KEY_W-1:0] mem_wdata;
    logic signed [mpq_pkg::KEY_W-1:0] rd_a_reg, rd_b_reg;

    // Request and working registers
    mpq_pkg::req_t                    req_reg, req_next;
    logic signed [mpq_pkg::KEY_W-1:0] key_reg, key_next;
    logic [mpq_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [IW-1:0]                    idx_reg, idx_next;
    logic signed [mpq_pkg::KEY_W-1:0] hold_reg, hold_next;
    logic signed [mpq_pkg::KEY_W-1:0] res_key_reg, res_key_next;
    mpq_pkg::status_t                 res_st_reg, res_st_next;
    logic signed [mpq_pkg::KEY_W-1:0] out_key_reg, out_key_next;
    logic [mpq_pkg::STATUS_W-1:0]     out_st_reg, out_st_next;
    logic [mpq_pkg::OCC_W-1:0]        out_occ_reg, out_occ_next;

    // Heap index arithmetic
    logic [IW-1:0]  parent;
    logic [CHW-1:0] left, right;
    logic           full, empty, badpos, notlarger;
    logic           l_ok, r_ok;
    logic signed [mpq_pkg::KEY_W-1:0] big_key;

    assign parent = IW'((idx_reg - 1'b1) >> 1);
    assign left   = {1'b0, idx_reg, 1'b1};
    assign right  = left + 1'b1;

    // Request checks
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign badpos    = (PCW'(pos_reg) >= PCW'(count_reg));
    assign notlarger = (key_reg <= rd_a_reg);

    // Sift-down child choice: left wins a tie, only strictly larger moves up
    assign l_ok    = (left < CHW'(count_reg)) && (rd_a_reg > hold_reg);
    assign big_key = l_ok ? rd_a_reg : hold_reg;
    assign r_ok    = (right < CHW'(count_reg)) && (rd_b_reg > big_key);

    always_comb begin
        stat.go_up = ((req_reg == mpq_pkg::REQ_INSERT) && !full) ||
                     ((req_reg == mpq_pkg::REQ_INCREASE) && !badpos && !notlarger);
        stat.go_dn = (req_reg == mpq_pkg::REQ_EXTRACT) && !empty;
        stat.up_more = (idx_reg != '0) && (rd_a_reg < hold_reg);
        stat.dn_more = l_ok || r_ok;
    end

    // Read address selection
    always_comb begin
        if (cmd.rd_up) begin
            addr_a = parent;
        end else if (cmd.rd_dn) begin
            addr_a = IW'(left);
        end else if (req_reg == mpq_pkg::REQ_INCREASE) begin
            addr_a = IW'(pos_reg);
        end else begin
            addr_a = '0;
        end
        addr_b = cmd.rd_dn ? IW'(right) : IW'(count_reg - 1'b1);
    end

    // Next values of the working registers and the memory write
    always_comb begin
        req_next     = req_reg;
        key_next     = key_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hold_next    = hold_reg;
        res_key_next = res_key_reg;
        res_st_next  = res_st_reg;
        out_key_next = out_key_reg;
        out_st_next  = out_st_reg;
        out_occ_next = out_occ_reg;
        mem_we       = 1'b0;
        mem_wdata    = hold_reg;

        if (cmd.capture) begin
            req_next = mpq_pkg::req_t'(s_req);
            key_next = s_key;
            pos_next = s_pos;
        end

        if (cmd.decide) begin
            res_key_next = '0;
            res_st_next  = mpq_pkg::ST_OK;
            unique case (req_reg)
                mpq_pkg::REQ_INSERT: begin
                    if (full) begin
                        res_st_next = mpq_pkg::ST_FULL;
                    end else begin
                        count_next = count_reg + 1'b1;
                        idx_next   = IW'(count_reg);
                        hold_next  = key_reg;
                    end
                end
                mpq_pkg::REQ_EXTRACT: begin
                    if (empty) begin
                        res_st_next = mpq_pkg::ST_EMPTY;
                    end else begin
                        res_key_next = rd_a_reg;
                        count_next   = count_reg - 1'b1;
                        idx_next     = '0;
                        hold_next    = rd_b_reg;
                    end
                end
                mpq_pkg::REQ_INCREASE: begin
                    if (badpos) begin
                        res_st_next = mpq_pkg::ST_BADPOS;
                    end else if (notlarger) begin
                        res_st_next = mpq_pkg::ST_NOTLARGER;
                    end else begin
                        idx_next  = IW'(pos_reg);
                        hold_next = key_reg;
                    end
                end
                mpq_pkg::REQ_PEEK: begin
                    if (empty) begin
                        res_st_next = mpq_pkg::ST_EMPTY;
                    end else begin
                        res_key_next = rd_a_reg;
                    end
                end
                default: begin
                    res_st_next = mpq_pkg::ST_OK;
                end
            endcase
        end

        // Sift-up: parent moves down into the hole, or the key settles
        if (cmd.ev_up) begin
            mem_we = 1'b1;
            if (stat.up_more) begin
                mem_wdata = rd_a_reg;
                idx_next  = parent;
            end else begin
                mem_wdata = hold_reg;
            end
        end

        // Sift-down: larger child moves up into the hole, or the key settles
        if (cmd.ev_dn) begin
            mem_we = 1'b1;
            if (r_ok) begin
                mem_wdata = rd_b_reg;
                idx_next  = IW'(right);
            end else if (l_ok) begin
                mem_wdata = rd_a_reg;
                idx_next  = IW'(left);
            end else begin
                mem_wdata = hold_reg;
            end
        end

        if (cmd.load_out) begin
            out_key_next = res_key_reg;
            out_st_next  = res_st_reg;
            out_occ_next = mpq_pkg::OCC_W'(count_reg);
        end
    end

    // Key memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[idx_reg] <= mem_wdata;
        end
        rd_a_reg <= key_mem[addr_a];
        rd_b_reg <= key_mem[addr_b];
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        hold_reg    <= hold_next;
        res_key_reg <= res_key_next;
        res_st_reg  <= res_st_next;
        out_key_reg <= out_key_next;
        out_st_reg  <= out_st_next;
        out_occ_reg <= out_occ_next;
    end

    assign m_key    = out_key_reg;
    assign m_status = out_st_reg;
    assign m_occ    = out_occ_reg;

endmodule

// ===== rtl/core/mpq_checker.sv =====
// Port-level checker for the max-heap priority queue, bound to the top level.
module mpq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [mpq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    localparam int ST_LSB = mpq_pkg::KEY_W;
    localparam int ST_MSB = ST_LSB + mpq_pkg::STATUS_W - 1;

    // No result is pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: not ready in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A failed request returns a zero key
    a_err_zero_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ST_MSB:ST_LSB] != mpq_pkg::ST_OK)
        |-> (m_tdata[mpq_pkg::KEY_W-1:0] == '0))
        else $error("nonzero key with error status");

endmodule

bind max_priority_queue_unit mpq_checker u_mpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== tb/tb_top.sv =====
// Testbench for max_priority_queue_unit: directed and random requests against a heap predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int CAPACITY    = 256;
    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int FLUSH_WAIT  = 40;     // wait after the last result before the final report
    localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [mpq_pkg::KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    // One expected result item
    typedef struct packed {
        logic signed [mpq_pkg::KEY_W-1:0] key;
        mpq_pkg::status_t                 status;
        logic [mpq_pkg::OCC_W-1:0]        occ;
    } heap_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic [mpq_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mpq_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tvalid;
    logic                            m_tready;

    // Predicted heap contents
    logic signed [mpq_pkg::KEY_W-1:0] heap_keys [CAPACITY];
    int unsigned                      heap_size;

    heap_result_t pending_results[$];
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;
    int unsigned  ready_hold;
    bit           idle_en;

    max_priority_queue_unit #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Move a key toward the root past strictly smaller parents
    function automatic void bubble_up(int unsigned idx);
        int unsigned                      up;
        logic signed [mpq_pkg::KEY_W-1:0] t;
        while (idx > 0) begin
            up = (idx - 1) / 2;
            if (heap_keys[idx] <= heap_keys[up])
                break;
            t              = heap_keys[idx];
            heap_keys[idx] = heap_keys[up];
            heap_keys[up]  = t;
            idx            = up;
        end
    endfunction

    // Apply one request to the predicted heap and return its result
    function automatic heap_result_t apply_request(mpq_pkg::req_t req,
                                                   logic signed [mpq_pkg::KEY_W-1:0] key,
                                                   logic [mpq_pkg::POS_W-1:0] pos);
        heap_result_t                     r;
        int unsigned                      hole;
        int unsigned                      big;
        int unsigned                      kid;
        logic signed [mpq_pkg::KEY_W-1:0] t;
        r.key    = '0;
        r.status = mpq_pkg::ST_OK;
        case (req)
            mpq_pkg::REQ_INSERT: begin
                if (heap_size >= CAPACITY) begin
                    r.status = mpq_pkg::ST_FULL;
                end else begin
                    heap_keys[heap_size] = key;
                    heap_size++;
                    bubble_up(heap_size - 1);
                end
            end
            mpq_pkg::REQ_EXTRACT: begin
                if (heap_size == 0) begin
                    r.status = mpq_pkg::ST_EMPTY;
                end else begin
                    r.key = heap_keys[0];
                    heap_size--;
                    heap_keys[0] = heap_keys[heap_size];
                    // sift down; left child wins a tie between children
                    hole = 0;
                    forever begin
                        big = hole;
                        kid = 2 * hole + 1;
                        if (kid < heap_size && heap_keys[kid] > heap_keys[big])
                            big = kid;
                        kid = kid + 1;
                        if (kid < heap_size && heap_keys[kid] > heap_keys[big])
                            big = kid;
                        if (big == hole)
                            break;
                        t               = heap_keys[hole];
                        heap_keys[hole] = heap_keys[big];
                        heap_keys[big]  = t;
                        hole            = big;
                    end
                end
            end
            mpq_pkg::REQ_INCREASE: begin
                if (pos >= heap_size) begin
                    r.status = mpq_pkg::ST_BADPOS;
                end else if (key <= heap_keys[pos]) begin
                    r.status = mpq_pkg::ST_NOTLARGER;
                end else begin
                    heap_keys[pos] = key;
                    bubble_up(pos);
                end
            end
            default: begin
                if (heap_size == 0)
                    r.status = mpq_pkg::ST_EMPTY;
                else
                    r.key = heap_keys[0];
            end
        endcase
        r.occ = heap_size[mpq_pkg::OCC_W-1:0];
        return r;
    endfunction

    // Random key: full range half the time, else small values for ties or the extremes
    function automatic logic signed [mpq_pkg::KEY_W-1:0] rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15) - 8;
            1: begin
                case ($urandom_range(0, 3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // New key for an increase at p: usually larger than the stored one
    function automatic logic signed [mpq_pkg::KEY_W-1:0] raised_key(int unsigned p);
        longint room;
        longint delta;
        if (p >= heap_size || $urandom_range(0, 6) == 0)
            return rand_key();
        room = longint'(KEY_MAX) - longint'(heap_keys[p]);
        if (room == 0)
            return heap_keys[p];
        if ($urandom_range(0, 1))
            delta = 1 + (longint'($urandom_range(0, 999)) % room);
        else
            delta = 1 + (longint'($urandom) % room);
        return mpq_pkg::KEY_W'(longint'(heap_keys[p]) + delta);
    endfunction

    // Random position over the whole 8-bit range
    function automatic logic [mpq_pkg::POS_W-1:0] rand_pos();
        return mpq_pkg::POS_W'($urandom_range(0, 255));
    endfunction

    // Position for an increase: mostly inside the heap
    function automatic logic [mpq_pkg::POS_W-1:0] pick_position();
        if (heap_size > 0 && $urandom_range(0, 99) < 85)
            return mpq_pkg::POS_W'($urandom_range(0, heap_size - 1));
        return rand_pos();
    endfunction

    // Send one item; called and returns at a falling edge
    task automatic send_request(mpq_pkg::req_t req, logic signed [mpq_pkg::KEY_W-1:0] key,
                                logic [mpq_pkg::POS_W-1:0] pos);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tdata  <= {6'b0, pos, key, req};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_request(req, key, pos));
        @(negedge aclk);
    endtask

    // Hold the sender until every expected result has come
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic send_increase();
        logic [mpq_pkg::POS_W-1:0] p;
        p = pick_position();
        send_request(mpq_pkg::REQ_INCREASE, raised_key(p), p);
    endtask

    // Empty heap: extract, peek and increase all fail
    task automatic test_empty();
        send_request(mpq_pkg::REQ_EXTRACT, KEY_MAX, 8'd0);
        send_request(mpq_pkg::REQ_PEEK, KEY_MIN, 8'd255);
        send_request(mpq_pkg::REQ_INCREASE, KEY_MAX, 8'd0);
        send_request(mpq_pkg::REQ_INCREASE, KEY_MAX, 8'd255);
    endtask

    // Key extremes, bad positions, not-larger increase, tie with the root
    task automatic test_extremes();
        send_request(mpq_pkg::REQ_INSERT, KEY_MIN, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, KEY_MAX, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, '0, 8'hff);
        send_request(mpq_pkg::REQ_INSERT, -1, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, KEY_MIN, 8'd0);
        send_request(mpq_pkg::REQ_PEEK, '0, 8'd0);
        send_request(mpq_pkg::REQ_INCREASE, KEY_MIN, 8'd4);
        send_request(mpq_pkg::REQ_INCREASE, KEY_MAX, 8'd5);
        send_request(mpq_pkg::REQ_INCREASE, KEY_MAX, 8'd255);
        send_request(mpq_pkg::REQ_INCREASE, KEY_MAX, 8'd4);
        repeat (6) send_request(mpq_pkg::REQ_EXTRACT, '0, 8'd0);
    endtask

    // Equal keys: sift-up and sift-down on ties
    task automatic test_ties();
        send_request(mpq_pkg::REQ_INSERT, 5, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, 5, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, 5, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, 7, 8'd0);
        send_request(mpq_pkg::REQ_INCREASE, 7, 8'd2);
        repeat (5) send_request(mpq_pkg::REQ_EXTRACT, '0, 8'd0);
    endtask

    // Fill to capacity, insert when full, increase and peek, then drain and extract from empty
    task automatic test_capacity();
        while (heap_size < CAPACITY)
            send_request(mpq_pkg::REQ_INSERT, rand_key(), rand_pos());
        send_request(mpq_pkg::REQ_INSERT, KEY_MAX, 8'd0);
        send_request(mpq_pkg::REQ_INSERT, KEY_MIN, 8'd255);
        send_request(mpq_pkg::REQ_INCREASE, raised_key(255), 8'd255);
        repeat (8) send_increase();
        send_request(mpq_pkg::REQ_PEEK, '0, 8'd0);
        while (heap_size > 0)
            send_request(mpq_pkg::REQ_EXTRACT, rand_key(), rand_pos());
        send_request(mpq_pkg::REQ_EXTRACT, '0, 8'd0);
    endtask

    // Random mix, with insert share changing so occupancy sweeps up and down
    task automatic test_random(int unsigned n_items);
        int unsigned grow;
        int unsigned pick;
        grow = 50;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 150 == 0)
                grow = $urandom_range(20, 80);
            if (i == n_items / 2)
                wait_for_drain();
            if (i == n_items - 200)
                idle_en = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_request(mpq_pkg::req_t'($urandom_range(0, 3)), $urandom, rand_pos());
            end else if (pick < grow) begin
                send_request(mpq_pkg::REQ_INSERT, rand_key(), rand_pos());
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    send_request(mpq_pkg::REQ_EXTRACT, rand_key(), rand_pos());
                else if (pick < 17)
                    send_increase();
                else
                    send_request(mpq_pkg::REQ_PEEK, rand_key(), rand_pos());
            end
        end
    endtask

    // Result stall: m_tready drops low in random bursts while idle_en is set
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            ready_hold <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        heap_result_t                     want;
        logic signed [mpq_pkg::KEY_W-1:0] got_key;
        logic [mpq_pkg::STATUS_W-1:0]     got_status;
        logic [mpq_pkg::OCC_W-1:0]        got_occ;
        if (aresetn && m_tvalid && m_tready) begin
            got_key    = m_tdata[31:0];
            got_status = m_tdata[34:32];
            got_occ    = m_tdata[43:35];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual key %0d status %0d occ %0d",
                         $time, got_key, got_status, got_occ);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got_key !== want.key) begin
                    $display("%0t: result_key expected %0d actual %0d", $time, want.key, got_key);
                    mismatch_count++;
                end
                if (got_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got_status);
                    mismatch_count++;
                end
                if (got_occ !== want.occ) begin
                    $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got_occ);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no item moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Test sequence
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        ready_hold     = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        heap_size      = 0;
        idle_en        = 1'b1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty();
        test_extremes();
        test_ties();
        test_capacity();
        test_random(1500);

        wait_for_drain();
        repeat (FLUSH_WAIT) @(negedge aclk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
